### rtl/core/fvcm_pkg.sv
// Shared types and codes for the file view cache manager.
// No dependencies.
`default_nettype none
package fvcm_pkg;
	localparam int unsigned SLOTS_DEF = 1024;
	localparam int unsigned WINDOW_LOG2_DEF = 16;

	localparam logic [2:0] MODE_ACQ = 3'd0;
	localparam logic [2:0] MODE_REL = 3'd1;
	localparam logic [2:0] MODE_RELD = 3'd2;
	localparam logic [2:0] MODE_WBS = 3'd3;
	localparam logic [2:0] MODE_WBD = 3'd4;
	localparam logic [2:0] MODE_PURGE = 3'd5;

	localparam logic [3:0] ST_HIT = 4'd0;
	localparam logic [3:0] ST_FREE = 4'd1;
	localparam logic [3:0] ST_REPL = 4'd2;
	localparam logic [3:0] ST_NONE = 4'd3;
	localparam logic [3:0] ST_REL = 4'd4;
	localparam logic [3:0] ST_WBS = 4'd5;
	localparam logic [3:0] ST_DEMPTY = 4'd6;
	localparam logic [3:0] ST_CLEAN = 4'd7;
	localparam logic [3:0] ST_REDIRTY = 4'd8;
	localparam logic [3:0] ST_PURGED = 4'd9;
	localparam logic [3:0] ST_BAD = 4'd10;

	localparam logic [1:0] DS_CLEAN = 2'd0;
	localparam logic [1:0] DS_DIRTY = 2'd1;
	localparam logic [1:0] DS_WB = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_SCAN,
		S_SCAN_LAST,
		S_APPLY,
		S_APPLY_WAIT,
		S_PURGE,
		S_PURGE_WAIT,
		S_DONE
	} state_t;

	// one slot record
	typedef struct packed {
		logic        in_use;
		logic [15:0] file;
		logic [31:0] window;
		logic [15:0] refs;
		logic [1:0]  dirt;
		logic        redirty;
		logic [31:0] stamp;
	} slot_rec_t;
endpackage
`default_nettype wire

### rtl/core/fvcm_slot_ram.sv
// Slot record memory: one write port, one registered read port.
// Depends on fvcm_pkg.
`default_nettype none
module fvcm_slot_ram #(
	parameter int unsigned SLOTS = fvcm_pkg::SLOTS_DEF,
	localparam int unsigned AW = $clog2(SLOTS)
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [AW-1:0]             waddr,
	input  fvcm_pkg::slot_rec_t      wdata,
	input  wire [AW-1:0]             raddr,
	output fvcm_pkg::slot_rec_t      rdata
);
	import fvcm_pkg::*;
	slot_rec_t mem [SLOTS];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/core/fvcm_fifo_ram.sv
// Free slot FIFO storage: one write port, one registered read port.
// Depends on fvcm_pkg.
`default_nettype none
module fvcm_fifo_ram #(
	parameter int unsigned SLOTS = fvcm_pkg::SLOTS_DEF,
	localparam int unsigned AW = $clog2(SLOTS)
) (
	input  wire          clk,
	input  wire          we,
	input  wire [AW-1:0] waddr,
	input  wire [AW-1:0] wdata,
	input  wire [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);
	import fvcm_pkg::*;
	logic [AW-1:0] mem [SLOTS];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/core/file_view_cache_manager.sv
// File view cache manager: top level, control sequencer around slot and FIFO memories.
// Depends on fvcm_pkg, fvcm_slot_ram, fvcm_fifo_ram.
//
// After reset the block clears the slot memory and loads the free FIFO,
// with busy high. Each command then scans the slot memory once through
// its single read port. Purge adds one selection pass per freed slot,
// each a full scan, to push freed slots in ascending window order.
// Results appear for one cycle with done high and must be taken then;
// the receiver cannot stall.
`default_nettype none
module file_view_cache_manager #(
	parameter int unsigned SLOTS = fvcm_pkg::SLOTS_DEF,
	parameter int unsigned WINDOW_LOG2 = fvcm_pkg::WINDOW_LOG2_DEF,
	localparam int unsigned AW = $clog2(SLOTS),
	localparam int unsigned CW = $clog2(SLOTS + 1)
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire [2:0]   mode,
	input  wire [15:0]  file_id,
	input  wire [47:0]  byte_offset,
	input  wire [9:0]   slot,
	output logic        done,
	output logic [3:0]  status,
	output logic [9:0]  slot_out,
	output logic [31:0] window_index,
	output logic [15:0] inner_offset,
	output logic [15:0] owner_file,
	output logic [15:0] victim_file,
	output logic [31:0] victim_window,
	output logic [10:0] freed_count,
	output logic        busy_skipped
);
	import fvcm_pkg::*;

	localparam int unsigned SW = CW + 1;

	state_t state_q, state_d;

	logic [2:0]  mode_q;
	logic [15:0] file_q;
	logic [31:0] win_q;
	logic [15:0] inner_q;
	logic [9:0]  sl_q;

	logic [AW-1:0] ptr_q;
	logic [AW-1:0] ra;
	logic          rvalid_q;
	logic [AW-1:0] rsl_q;

	logic [31:0] stamp_cnt_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;

	logic          hit_q;
	logic [AW-1:0] hit_idx_q;
	logic          lru_q;
	logic [AW-1:0] lru_idx_q;
	logic [31:0]   lru_age_q;
	logic          dq_q;
	logic [AW-1:0] dq_idx_q;
	logic [31:0]   dq_age_q;
	logic          busy_sk_q;
	logic [10:0]   freed_q;
	// purge selection: lowest window above the last one pushed
	logic          pg_have_q;
	logic [AW-1:0] pg_idx_q;
	logic [31:0]   pg_win_q;
	logic          pg_lastv_q;
	logic [31:0]   pg_last_q;

	slot_rec_t rd, wd;
	logic          we;
	logic [AW-1:0] wa;
	logic          fwe;
	logic [AW-1:0] fwa, fwd, fra, frd;

	fvcm_slot_ram #(.SLOTS(SLOTS)) u_slot (
		.clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd)
	);
	fvcm_fifo_ram #(.SLOTS(SLOTS)) u_fifo (
		.clk(clk), .we(fwe), .waddr(fwa), .wdata(fwd), .raddr(fra), .rdata(frd)
	);

	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
	logic sl_ok;
	assign sl_ok = ({22'd0, sl_q} < 32'(SLOTS));

	logic [SW-1:0] fsum;
	logic [AW-1:0] ftail;
	assign fsum = SW'(head_q) + SW'(count_q);
	assign ftail = AW'((fsum >= SW'(SLOTS)) ? fsum - SW'(SLOTS) : fsum);

	logic [31:0] age;
	logic m_hit, m_lru, m_dq, m_pg;
	always_comb begin
		age = stamp_cnt_q - rd.stamp;
		m_hit = rd.in_use && rd.file == file_q && rd.window == win_q;
		m_lru = rd.in_use && rd.dirt == DS_CLEAN && rd.refs == 16'd0;
		m_dq = rd.in_use && rd.dirt == DS_DIRTY;
		m_pg = rd.in_use && rd.file == file_q && rd.dirt != DS_WB && rd.refs == 16'd0
			&& (!pg_lastv_q || rd.window > pg_last_q);
	end

	logic [AW-1:0] tgt;
	always_comb begin
		tgt = hit_idx_q;
		case (mode_q)
			MODE_ACQ: tgt = hit_q ? hit_idx_q : (count_q != '0 ? frd : lru_idx_q);
			MODE_WBS: tgt = dq_idx_q;
			MODE_REL, MODE_RELD, MODE_WBD: tgt = AW'(sl_q);
			default: tgt = hit_idx_q;
		endcase
	end

	logic [3:0]  st_r;
	logic [9:0]  so_r;
	logic [31:0] wi_r, vw_r;
	logic [15:0] io_r, of_r, vf_r;
	logic        stamp_inc;

	always_comb begin
		state_d = state_q;
		ra = ptr_q;
		we = 1'b0;
		wa = ptr_q;
		wd = rd;
		fwe = 1'b0;
		fwa = ptr_q;
		fwd = ptr_q;
		fra = head_q;
		stamp_inc = 1'b0;
		st_r = ST_BAD; so_r = '0; wi_r = '0; io_r = '0; of_r = '0; vf_r = '0; vw_r = '0;
		case (state_q)
			S_INIT: begin
				we = 1'b1;
				wd = '0;
				fwe = 1'b1;
				if (ptr_q == LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (ptr_q == LAST) state_d = S_SCAN_LAST;
			end
			S_SCAN_LAST: begin
				ra = tgt;
				state_d = S_APPLY_WAIT;
			end
			S_APPLY_WAIT: begin
				ra = tgt;
				if (mode_q == MODE_PURGE) state_d = pg_have_q ? S_PURGE : S_DONE;
				else state_d = S_APPLY;
			end
			S_APPLY: begin
				wa = tgt;
				wd = rd;
				state_d = S_DONE;
				case (mode_q)
					MODE_ACQ: begin
						if (hit_q || count_q != '0 || lru_q) begin
							we = 1'b1;
							if (hit_q) begin
								st_r = ST_HIT;
								if (rd.refs != 16'hFFFF) wd.refs = rd.refs + 16'd1;
							end else begin
								st_r = (count_q != '0) ? ST_FREE : ST_REPL;
								if (count_q == '0) begin
									vf_r = rd.file;
									vw_r = rd.window;
								end
								wd.in_use = 1'b1;
								wd.file = file_q;
								wd.window = win_q;
								wd.refs = 16'd1;
								wd.dirt = DS_CLEAN;
								wd.redirty = 1'b0;
							end
							so_r = 10'(tgt);
							wi_r = win_q;
							io_r = inner_q;
						end else begin
							st_r = ST_NONE;
						end
					end
					MODE_REL, MODE_RELD: begin
						if (sl_ok && rd.in_use && rd.refs != 16'd0) begin
							we = 1'b1;
							if (mode_q == MODE_RELD && rd.dirt == DS_CLEAN) begin
								wd.dirt = DS_DIRTY;
								wd.stamp = stamp_cnt_q;
								stamp_inc = 1'b1;
							end else if (mode_q == MODE_RELD && rd.dirt == DS_WB) begin
								wd.redirty = 1'b1;
							end
							wd.refs = rd.refs - 16'd1;
							if (wd.refs == 16'd0 && wd.dirt == DS_CLEAN) begin
								wd.stamp = stamp_cnt_q;
								stamp_inc = 1'b1;
							end
							st_r = ST_REL;
							so_r = sl_q;
						end
					end
					MODE_WBS: begin
						if (!dq_q) st_r = ST_DEMPTY;
						else begin
							we = 1'b1;
							wd.dirt = DS_WB;
							wd.redirty = 1'b0;
							st_r = ST_WBS;
							so_r = 10'(tgt);
							wi_r = rd.window;
							of_r = rd.file;
						end
					end
					MODE_WBD: begin
						if (sl_ok && rd.in_use && rd.dirt == DS_WB) begin
							we = 1'b1;
							if (rd.redirty) begin
								wd.dirt = DS_DIRTY;
								wd.redirty = 1'b0;
								wd.stamp = stamp_cnt_q;
								stamp_inc = 1'b1;
								st_r = ST_REDIRTY;
							end else begin
								wd.dirt = DS_CLEAN;
								if (rd.refs == 16'd0) begin
									wd.stamp = stamp_cnt_q;
									stamp_inc = 1'b1;
								end
								st_r = ST_CLEAN;
							end
							so_r = sl_q;
							wi_r = rd.window;
							of_r = rd.file;
						end
					end
					default: st_r = ST_BAD;
				endcase
			end
			S_PURGE: begin
				we = 1'b1;
				wa = pg_idx_q;
				wd = '0;
				fwe = (count_q != CW'(SLOTS));
				fwa = ftail;
				fwd = pg_idx_q;
				state_d = S_PURGE_WAIT;
			end
			S_PURGE_WAIT: begin
				state_d = S_SCAN;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// scanning phase sees read data in the cycle after its address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ptr_q <= '0;
			rvalid_q <= 1'b0;
			stamp_cnt_q <= '0;
			head_q <= '0;
			count_q <= CW'(SLOTS);
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= 1'b0;
			rvalid_q <= (state_q == S_SCAN);
			rsl_q <= ptr_q;
			if (state_q == S_INIT || state_q == S_SCAN)
				ptr_q <= (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
			if (stamp_inc) stamp_cnt_q <= stamp_cnt_q + 32'd1;
			if (state_q == S_APPLY && mode_q == MODE_ACQ && !hit_q && count_q != '0) begin
				head_q <= (head_q == LAST) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (state_q == S_PURGE && count_q != CW'(SLOTS)) count_q <= count_q + 1'b1;
			if (state_q == S_APPLY
				|| (state_q == S_APPLY_WAIT && mode_q == MODE_PURGE && !pg_have_q))
				done <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q <= mode;
			file_q <= file_id;
			win_q <= 32'(byte_offset >> WINDOW_LOG2);
			inner_q <= 16'(byte_offset & ((48'd1 << WINDOW_LOG2) - 48'd1));
			sl_q <= slot;
			busy_sk_q <= 1'b0;
			freed_q <= '0;
			pg_lastv_q <= 1'b0;
		end
		if ((state_q == S_IDLE && start) || state_q == S_PURGE_WAIT) begin
			hit_q <= 1'b0; lru_q <= 1'b0; dq_q <= 1'b0; pg_have_q <= 1'b0;
		end
		if (state_q == S_PURGE) begin
			pg_lastv_q <= 1'b1;
			pg_last_q <= pg_win_q;
			freed_q <= freed_q + 11'd1;
		end
		if (rvalid_q) begin
			if (m_hit && !hit_q) begin hit_q <= 1'b1; hit_idx_q <= rsl_q; end
			if (m_lru && (!lru_q || age > lru_age_q)) begin
				lru_q <= 1'b1; lru_idx_q <= rsl_q; lru_age_q <= age;
			end
			if (m_dq && (!dq_q || age > dq_age_q)) begin
				dq_q <= 1'b1; dq_idx_q <= rsl_q; dq_age_q <= age;
			end
			if (rd.in_use && rd.file == file_q && rd.dirt == DS_WB) busy_sk_q <= 1'b1;
			if (m_pg && (!pg_have_q || rd.window < pg_win_q)) begin
				pg_have_q <= 1'b1; pg_idx_q <= rsl_q; pg_win_q <= rd.window;
			end
		end
	end

	logic pdone;
	assign pdone = (mode_q == MODE_PURGE) && state_q == S_APPLY_WAIT && !pg_have_q;

	always_ff @(posedge clk) begin
		if (state_q == S_APPLY) begin
			status <= st_r; slot_out <= so_r; window_index <= wi_r; inner_offset <= io_r;
			owner_file <= of_r; victim_file <= vf_r; victim_window <= vw_r;
			freed_count <= '0; busy_skipped <= 1'b0;
		end else if (pdone) begin
			status <= (mode_q == MODE_PURGE) ? ST_PURGED : ST_BAD;
			slot_out <= '0; window_index <= '0; inner_offset <= '0;
			owner_file <= '0; victim_file <= '0; victim_window <= '0;
			freed_count <= freed_q; busy_skipped <= busy_sk_q;
		end
	end

	// unknown modes run as one scan and finish through S_APPLY with bad status
	assign busy = (state_q != S_IDLE);

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !$past(done));
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(SLOTS))
		else $error("free count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> busy) else $error("start not taken");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status != ST_PURGED || mode_q == MODE_PURGE)) else $error("bad purge status");
endmodule
`default_nettype wire

### sim/fvcm_checker.sv
// Result checker for the file view cache manager: watches the command and result channels,
// keeps its own copy of the slot pool and compares every result word field by field.
// Depends on fvcm_pkg.
`timescale 1ns / 1ps
module fvcm_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire         busy,
	input  wire [2:0]   mode,
	input  wire [15:0]  file_id,
	input  wire [47:0]  byte_offset,
	input  wire [9:0]   slot,
	input  wire         done,
	input  wire [3:0]   status,
	input  wire [9:0]   slot_out,
	input  wire [31:0]  window_index,
	input  wire [15:0]  inner_offset,
	input  wire [15:0]  owner_file,
	input  wire [15:0]  victim_file,
	input  wire [31:0]  victim_window,
	input  wire [10:0]  freed_count,
	input  wire         busy_skipped,
	output int          pending,
	output int          errors
);
	import fvcm_pkg::*;

	localparam int NS = 1024;

	typedef struct {
		logic [3:0]  st;
		logic [9:0]  sl;
		logic [31:0] win;
		logic [15:0] inner;
		logic [15:0] owner;
		logic [15:0] vfile;
		logic [31:0] vwin;
		logic [10:0] freed;
		logic        skipped;
	} word_t;

	logic        used   [NS];
	logic [15:0] sfile  [NS];
	logic [31:0] swin   [NS];
	logic [15:0] refs   [NS];
	logic [1:0]  dirt   [NS];
	logic        redirt [NS];
	logic [31:0] qstamp [NS];
	logic [31:0] stamp_ctr;
	logic [9:0]  free_q [NS];
	int          free_head;
	int          free_cnt;
	word_t       expected_words[$];

	assign pending = expected_words.size();

	task automatic report(input string fld, input logic [63:0] got, input logic [63:0] want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $time, fld, got, want);
		errors++;
	endtask

	task automatic stamp(input int s);
		qstamp[s] = stamp_ctr;
		stamp_ctr++;
	endtask

	function automatic int oldest(input logic dirty_q);
		int best;
		logic [31:0] best_age;
		logic [31:0] age;
		logic member;
		best = -1;
		best_age = '0;
		for (int i = 0; i < NS; i++) begin
			if (dirty_q)
				member = used[i] && dirt[i] == DS_DIRTY;
			else
				member = used[i] && dirt[i] == DS_CLEAN && refs[i] == 16'd0;
			if (member) begin
				age = stamp_ctr - qstamp[i];
				if (best < 0 || age > best_age) begin
					best = i;
					best_age = age;
				end
			end
		end
		return best;
	endfunction

	task automatic claim(input int s, input logic [15:0] f, input logic [31:0] w);
		used[s] = 1'b1;
		sfile[s] = f;
		swin[s] = w;
		refs[s] = 16'd1;
		dirt[s] = DS_CLEAN;
		redirt[s] = 1'b0;
	endtask

	task automatic run_command(input logic [2:0] m, input logic [15:0] f, input logic [47:0] b,
			input logic [9:0] s, output word_t e);
		int found;
		int n;
		int j;
		logic [31:0] w;
		int order[NS];
		e = '{st: ST_BAD, default: '0};
		w = b[47:16];
		case (m)
			MODE_ACQ: begin
				found = -1;
				for (int i = 0; i < NS; i++)
					if (found < 0 && used[i] && sfile[i] == f && swin[i] == w)
						found = i;
				if (found >= 0) begin
					if (refs[found] != 16'hFFFF)
						refs[found]++;
					e.st = ST_HIT;
				end else if (free_cnt > 0) begin
					found = int'(free_q[free_head]);
					free_head = (free_head + 1) % NS;
					free_cnt--;
					claim(found, f, w);
					e.st = ST_FREE;
				end else begin
					found = oldest(1'b0);
					if (found >= 0) begin
						e.vfile = sfile[found];
						e.vwin = swin[found];
						claim(found, f, w);
						e.st = ST_REPL;
					end else
						e.st = ST_NONE;
				end
				if (found >= 0) begin
					e.sl = 10'(found);
					e.win = w;
					e.inner = b[15:0];
				end
			end
			MODE_REL, MODE_RELD: begin
				if (used[s] && refs[s] != 16'd0) begin
					if (m == MODE_RELD) begin
						if (dirt[s] == DS_CLEAN) begin
							dirt[s] = DS_DIRTY;
							stamp(int'(s));
						end else if (dirt[s] == DS_WB)
							redirt[s] = 1'b1;
					end
					refs[s]--;
					if (refs[s] == 16'd0 && dirt[s] == DS_CLEAN)
						stamp(int'(s));
					e.st = ST_REL;
					e.sl = s;
				end
			end
			MODE_WBS: begin
				found = oldest(1'b1);
				if (found < 0)
					e.st = ST_DEMPTY;
				else begin
					dirt[found] = DS_WB;
					redirt[found] = 1'b0;
					e.st = ST_WBS;
					e.sl = 10'(found);
					e.win = swin[found];
					e.owner = sfile[found];
				end
			end
			MODE_WBD: begin
				if (used[s] && dirt[s] == DS_WB) begin
					if (redirt[s]) begin
						dirt[s] = DS_DIRTY;
						redirt[s] = 1'b0;
						stamp(int'(s));
						e.st = ST_REDIRTY;
					end else begin
						dirt[s] = DS_CLEAN;
						if (refs[s] == 16'd0)
							stamp(int'(s));
						e.st = ST_CLEAN;
					end
					e.sl = s;
					e.win = swin[s];
					e.owner = sfile[s];
				end
			end
			MODE_PURGE: begin
				n = 0;
				for (int i = 0; i < NS; i++) begin
					if (used[i] && sfile[i] == f) begin
						if (dirt[i] == DS_WB)
							e.skipped = 1'b1;
						else if (refs[i] == 16'd0) begin
							j = n;
							while (j > 0 && swin[order[j-1]] > swin[i]) begin
								order[j] = order[j-1];
								j--;
							end
							order[j] = i;
							n++;
						end
					end
				end
				for (int k = 0; k < n; k++) begin
					used[order[k]] = 1'b0;
					dirt[order[k]] = DS_CLEAN;
					redirt[order[k]] = 1'b0;
					refs[order[k]] = 16'd0;
					if (free_cnt < NS) begin
						free_q[(free_head + free_cnt) % NS] = 10'(order[k]);
						free_cnt++;
					end
				end
				e.st = ST_PURGED;
				e.freed = 11'(n);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_t e;
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				used[i] = 1'b0;
				sfile[i] = '0;
				swin[i] = '0;
				refs[i] = '0;
				dirt[i] = DS_CLEAN;
				redirt[i] = 1'b0;
				qstamp[i] = '0;
				free_q[i] = 10'(i);
			end
			stamp_ctr = '0;
			free_head = 0;
			free_cnt = NS;
			expected_words.delete();
			errors = 0;
		end else begin
			if (start && !busy) begin
				run_command(mode, file_id, byte_offset, slot, e);
				expected_words.push_back(e);
			end
			if (done) begin
				if (expected_words.size() == 0)
					report("unexpected word", {60'd0, status}, 64'd0);
				else begin
					e = expected_words.pop_front();
					if (status !== e.st) report("status", 64'(status), 64'(e.st));
					if (slot_out !== e.sl) report("slot_out", 64'(slot_out), 64'(e.sl));
					if (window_index !== e.win)
						report("window_index", 64'(window_index), 64'(e.win));
					if (inner_offset !== e.inner)
						report("inner_offset", 64'(inner_offset), 64'(e.inner));
					if (owner_file !== e.owner)
						report("owner_file", 64'(owner_file), 64'(e.owner));
					if (victim_file !== e.vfile)
						report("victim_file", 64'(victim_file), 64'(e.vfile));
					if (victim_window !== e.vwin)
						report("victim_window", 64'(victim_window), 64'(e.vwin));
					if (freed_count !== e.freed)
						report("freed_count", 64'(freed_count), 64'(e.freed));
					if (busy_skipped !== e.skipped)
						report("busy_skipped", 64'(busy_skipped), 64'(e.skipped));
				end
			end
		end
	end
endmodule

### sim/tb_file_view_cache_manager.sv
// Testbench top for the file view cache manager: clock, reset and command stimulus.
// Depends on fvcm_pkg, file_view_cache_manager and fvcm_checker.
`timescale 1ns / 1ps
module tb_file_view_cache_manager;
	import fvcm_pkg::*;

	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;
	localparam int RANDOM_ITEMS = 557;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic [2:0]  mode;
	logic [15:0] file_id;
	logic [47:0] byte_offset;
	logic [9:0]  slot;
	wire         busy;
	wire         done;
	wire [3:0]   status;
	wire [9:0]   slot_out;
	wire [31:0]  window_index;
	wire [15:0]  inner_offset;
	wire [15:0]  owner_file;
	wire [15:0]  victim_file;
	wire [31:0]  victim_window;
	wire [10:0]  freed_count;
	wire         busy_skipped;
	int          pending;
	int          errors;
	int          burst_left;
	logic [9:0]  held_slots[$];
	logic [9:0]  wb_slots[$];

	file_view_cache_manager u_top (.*);
	fvcm_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk)
		if (done) begin
			if (status == ST_HIT || status == ST_FREE || status == ST_REPL)
				held_slots.push_back(slot_out);
			if (status == ST_WBS)
				wb_slots.push_back(slot_out);
		end

	task automatic send(input logic [2:0] m, input logic [15:0] f, input logic [47:0] b,
			input logic [9:0] s);
		int gap;
		@(posedge clk);
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		start <= 1;
		mode <= m;
		file_id <= f;
		byte_offset <= b;
		slot <= s;
		do @(negedge clk); while (busy);
		@(posedge clk);
		start <= 0;
	endtask

	task automatic drain();
		do @(negedge clk); while (pending != 0);
	endtask

	function automatic logic [9:0] take(ref logic [9:0] q[$]);
		int k;
		logic [9:0] s;
		if (q.size() == 0 || $urandom_range(0, 9) == 0)
			return 10'($urandom_range(0, 1023));
		k = $urandom_range(0, q.size() - 1);
		s = q[k];
		q.delete(k);
		return s;
	endfunction

	task automatic random_item();
		int pick;
		logic [15:0] f;
		logic [47:0] b;
		pick = $urandom_range(0, 99);
		f = 16'($urandom_range(0, 7));
		b = 48'({$urandom, $urandom});
		b[47:16] = $urandom_range(0, 15);
		if ($urandom_range(0, 19) == 0) begin
			f = 16'($urandom);
			b = 48'({$urandom, $urandom});
		end
		if ($urandom_range(0, 3) == 0)
			f = 16'h8000 + 16'($urandom_range(0, 128));
		if (pick < 30)
			send(MODE_ACQ, f, b, 10'($urandom));
		else if (pick < 48)
			send(MODE_REL, f, b, take(held_slots));
		else if (pick < 66)
			send(MODE_RELD, f, b, take(held_slots));
		else if (pick < 78)
			send(MODE_WBS, f, b, 10'($urandom));
		else if (pick < 90)
			send(MODE_WBD, f, b, take(wb_slots));
		else if (pick < 97)
			send(MODE_PURGE, f, b, 10'($urandom));
		else
			send(pick[0] ? MODE_RSVD6 : MODE_RSVD7, f, b, 10'($urandom));
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		mode = MODE_ACQ;
		file_id = 0;
		byte_offset = 0;
		slot = 0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;

		send(MODE_ACQ, 16'h0000, 48'h0, 10'd0);
		send(MODE_ACQ, 16'h0000, 48'h1234, 10'd0);
		send(MODE_ACQ, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 10'd0);
		send(MODE_RELD, 16'h0, 48'h0, 10'd0);
		send(MODE_WBS, 16'h0, 48'h0, 10'd0);
		send(MODE_RELD, 16'h0, 48'h0, 10'd0);
		send(MODE_WBD, 16'h0, 48'h0, 10'd0);
		send(MODE_WBS, 16'h0, 48'h0, 10'd0);
		send(MODE_WBD, 16'h0, 48'h0, 10'd0);
		send(MODE_REL, 16'h0, 48'h0, 10'd0);
		send(MODE_REL, 16'h0, 48'h0, 10'd1023);
		send(MODE_WBD, 16'h0, 48'h0, 10'd1);
		send(MODE_WBS, 16'h0, 48'h0, 10'd0);
		send(MODE_PURGE, 16'h0000, 48'h0, 10'd0);
		send(MODE_PURGE, 16'hFFFF, 48'h0, 10'd0);
		send(MODE_RSVD6, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 10'h3FF);
		send(MODE_RSVD7, 16'h0, 48'h0, 10'd0);
		send(MODE_REL, 16'h0, 48'h0, 10'd1);
		send(MODE_ACQ, 16'h0002, 48'h3_0000, 10'd0);
		send(MODE_RELD, 16'h0, 48'h0, 10'd2);
		send(MODE_WBS, 16'h0, 48'h0, 10'd0);
		send(MODE_PURGE, 16'h0002, 48'h0, 10'd0);
		send(MODE_WBD, 16'h0, 48'h0, 10'd2);
		drain();
		held_slots.delete();
		wb_slots.delete();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			random_item();
			if (i == RANDOM_ITEMS / 2)
				drain();
		end

		fork
			drain();
			begin
				repeat (2_000_000) @(posedge clk);
			end
		join_any
		disable fork;
		repeat (2100) @(posedge clk);
		if (pending == 0 && errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
